@@ rtl/hzd_pkg.sv @@
// hzd_pkg: constants and types shared by the hz stream decoder
// holds the escape characters, the word layouts and the decoder state record
// no dependencies
package hzd_pkg;

	localparam logic [7:0] CH_TILDE   = 8'h7e;
	localparam logic [7:0] CH_OPEN    = 8'h7b;
	localparam logic [7:0] CH_CLOSE   = 8'h7d;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CTRL_MAX   = 8'h1f;

	// input word: one raw byte of the hz stream
	typedef struct packed {
		logic [7:0] in_byte;
	} hzd_in_t;

	// output word: one decoded character
	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       double_byte;
		logic       last;
	} hzd_out_t;

	typedef struct packed {
		logic       gb_mode;
		logic       tilde_pending;
		logic       lead_valid;
		logic [7:0] lead_byte;
	} hzd_state_t;

	// characters produced by one raw byte, res[0] goes out first
	typedef struct packed {
		logic [1:0]          cnt;
		hzd_out_t [1:0]      res;
	} hzd_dec_t;

endpackage

@@ rtl/hzd_stream_if.sv @@
// hzd_stream_if: valid/ready channel carrying one word per handshake
// the word type is set per instance; used with types from hzd_pkg
interface hzd_stream_if #(
	parameter type data_t = logic [7:0]
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hz_gb2312_stream_decoder_core.sv @@
// hz_gb2312_stream_decoder_core: hz (gb2312) stream decoder, top level
// depends on hzd_pkg, hzd_stream_if and hzd_decode
//
// usage:
//   stream: raw hz bytes in, one byte per word (data.in_byte).
//   chars:  decoded characters out, one per word; double_byte marks a gb2312
//           pair, last marks the final character caused by one raw byte.
//   a raw byte is decoded in the cycle it is taken and its characters land in
//   a two-word output register, so the first character is offered in the cycle
//   after the byte is accepted.
//   throughput is one raw byte per cycle while the receiver keeps up; a byte
//   is taken only when the output register will be empty after this cycle,
//   so a byte that yields two characters (an invalid escape) holds off the
//   next byte while the second character drains.
//   when chars is stalled the output register holds its words and stream
//   ready drops; no word is lost or repeated.
//   reset (arst_n low) clears the mode to ascii, drops any pending tilde or
//   held lead byte and empties the output register.
module hz_gb2312_stream_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	hzd_stream_if.sink   stream,
	hzd_stream_if.source chars
);
	import hzd_pkg::*;

	hzd_state_t st_q, st_next;
	hzd_dec_t   dec;
	hzd_in_t    in_word;
	hzd_out_t   res_q [2];
	logic [1:0] cnt_q, cnt_after_pop;
	logic       push, pop;

	assign in_word = stream.data;

	hzd_decode u_decode (
		.in_byte (in_word.in_byte),
		.st      (st_q),
		.st_next (st_next),
		.dec     (dec)
	);

	assign pop           = chars.valid && chars.ready;
	assign cnt_after_pop = cnt_q - {1'b0, pop};
	// take a byte only if both output slots are free after this cycle
	assign stream.ready  = (cnt_after_pop == 2'd0);
	assign push          = stream.valid && stream.ready;

	assign chars.valid = (cnt_q != 2'd0);
	assign chars.data  = res_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				st_q  <= st_next;
				cnt_q <= dec.cnt;
			end else begin
				cnt_q <= cnt_after_pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[0] <= dec.res[0];
			res_q[1] <= dec.res[1];
		end else if (pop) begin
			res_q[0] <= res_q[1];
		end
	end

endmodule

@@ rtl/hzd_decode.sv @@
// hzd_decode: combinational step of the hz decoder for one raw byte
// gives the next state and up to two decoded characters; depends on hzd_pkg
module hzd_decode (
	input  logic [7:0]          in_byte,
	input  hzd_pkg::hzd_state_t st,
	output hzd_pkg::hzd_state_t st_next,
	output hzd_pkg::hzd_dec_t   dec
);
	import hzd_pkg::*;

	logic plain_single;

	// a control byte, or a non-tilde ascii-mode byte, passes through
	assign plain_single = (in_byte <= CTRL_MAX) || !st.gb_mode;

	always_comb begin
		st_next = st;
		dec     = '0;
		if (st.lead_valid) begin
			dec.res[0]        = '{first_byte: st.lead_byte, second_byte: in_byte,
				double_byte: 1'b1, last: 1'b1};
			dec.cnt           = 2'd1;
			st_next.lead_valid = 1'b0;
			st_next.lead_byte  = '0;
		end else if (st.tilde_pending) begin
			st_next.tilde_pending = 1'b0;
			case (in_byte)
				CH_TILDE: begin
					dec.res[0] = '{first_byte: CH_TILDE, second_byte: 8'h00,
						double_byte: 1'b0, last: 1'b1};
					dec.cnt    = 2'd1;
				end
				CH_OPEN: st_next.gb_mode = 1'b1;
				CH_CLOSE: st_next.gb_mode = 1'b0;
				CH_NEWLINE: ;
				default: begin
					// invalid escape: emit the tilde, then treat the byte afresh
					dec.res[0] = '{first_byte: CH_TILDE, second_byte: 8'h00,
						double_byte: 1'b0, last: !plain_single};
					if (plain_single) begin
						dec.res[1] = '{first_byte: in_byte, second_byte: 8'h00,
							double_byte: 1'b0, last: 1'b1};
						dec.cnt    = 2'd2;
					end else begin
						dec.cnt            = 2'd1;
						st_next.lead_valid = 1'b1;
						st_next.lead_byte  = in_byte;
					end
				end
			endcase
		end else if (in_byte == CH_TILDE) begin
			st_next.tilde_pending = 1'b1;
		end else if (plain_single) begin
			dec.res[0] = '{first_byte: in_byte, second_byte: 8'h00,
				double_byte: 1'b0, last: 1'b1};
			dec.cnt    = 2'd1;
		end else begin
			st_next.lead_valid = 1'b1;
			st_next.lead_byte  = in_byte;
		end
	end

endmodule
